// ===== sv/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg
// Widths, register codes, limits and shared types of the pressure sensor
// compensation pipeline.
// ----------------------------------------------------------------------------
package psc_pkg;

  // Field widths
  localparam int RawW     = 24;
  localparam int CoefW    = 16;
  localparam int CfgIdxW  = 3;
  localparam int TempW    = 19;
  localparam int PresW    = 25;

  // Internal widths
  localparam int DtW       = 25;           // D2 - C5*256
  localparam int MulW      = 42;           // dt times a calibration word
  localparam int SqFullW   = 2 * DtW;      // dt squared, full product
  localparam int SqW       = 48;           // dt squared, magnitude bits
  localparam int QW        = 18;           // dt*C6/2^23
  localparam int T2W       = 17;
  localparam int OffW      = 38;
  localparam int SensW     = 37;
  localparam int QqFullW   = 2 * QW;
  localparam int QqW       = 35;
  localparam int TempFullW = TempW + 1;
  localparam int SplitW    = 19;           // low part of SENS in the split multiply
  localparam int LoProdW   = RawW + SplitW;
  localparam int HiProdW   = RawW + 1 + SensW - SplitW;
  localparam int ProdW     = 62;
  localparam int PdivW     = 41;
  localparam int DiffW     = 42;
  localparam int PresFullW = 27;

  // Scaling shifts
  localparam int RefTempShift  = 8;
  localparam int TempShift     = 23;
  localparam int T2Shift       = 33;
  localparam int OffShift      = 5;
  localparam int SensShift     = 7;
  localparam int OffBaseShift  = 18;
  localparam int SensBaseShift = 17;
  localparam int ProdShift     = 21;
  localparam int PresShift     = 15;
  localparam int Frac2Shift    = 3;

  // Reference temperature and output limits
  localparam int TempRefCenti = 2000;
  localparam int TempMin      = -262144;
  localparam int TempMax      = 262143;
  localparam int PresMin      = -16777216;
  localparam int PresMax      = 16777215;

  // Pipeline depth
  localparam int NumStages = 8;

  // Calibration register codes
  typedef enum logic [CfgIdxW-1:0] {
    CfgSensBase,
    CfgOffsetBase,
    CfgSensTc,
    CfgOffsetTc,
    CfgRefTemp,
    CfgTempSlope
  } psc_cfg_idx_e;

  // Calibration words
  typedef struct packed {
    logic [CoefW-1:0] sens_base;
    logic [CoefW-1:0] offset_base;
    logic [CoefW-1:0] sens_tc;
    logic [CoefW-1:0] offset_tc;
    logic [CoefW-1:0] ref_temp;
    logic [CoefW-1:0] temp_slope;
  } psc_coef_t;

  // Stage occupancy and load enables
  typedef struct packed {
    logic [NumStages-1:0] valid;
    logic [NumStages-1:0] en;
  } psc_pipe_t;

endpackage

// ===== sv/psc_if.sv =====
// ----------------------------------------------------------------------------
// psc_if
// Valid/ready channels of the compensation block: raw sample in, result out
// and calibration register writes.
// ----------------------------------------------------------------------------
interface psc_in_if import psc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RawW-1:0] raw_pressure;
  logic [RawW-1:0] raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature,
                  input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature,
                  output ready);
endinterface

interface psc_out_if import psc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [TempW-1:0] temperature_centi;
  logic signed [PresW-1:0] pressure_centi_mbar;

  modport source (output valid, output temperature_centi,
                  output pressure_centi_mbar, input ready);
  modport sink   (input valid, input temperature_centi,
                  input pressure_centi_mbar, output ready);
endinterface

interface psc_cfg_if import psc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CoefW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/pressure_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// pressure_sensor_compensation
// Second-order compensation of a 5 bar pressure sensor: raw D1/D2 words in,
// temperature in 0.01 C and pressure in 0.01 mbar out.
// ----------------------------------------------------------------------------
//
//  Port       Dir  Word                                     Role
//  cfg_i      in   index[2:0], data[15:0]                   calibration C1..C6
//  sample_i   in   raw_pressure[23:0], raw_temperature[23:0] D1 / D2 conversion
//  result_o   out  temperature_centi[18:0],                 compensated result
//                  pressure_centi_mbar[24:0]
//
//  Eight register stages; one word enters per cycle unless a stall on result_o
//  has filled every stage, and its result is valid once it reaches the last
//  stage. Throughput matches that rate; stages 1, 3 and 5 hold the multiplies.
//  rst_ni clears the stage valid bits and the calibration words to zero.
//  A stall on result_o holds full stages; empty stages still fill, so the
//  input keeps taking words until all eight stages are full.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation import psc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  psc_cfg_if.sink    cfg_i,
  psc_in_if.sink     sample_i,
  psc_out_if.source  result_o
);

  psc_coef_t               coef;
  psc_pipe_t               ctrl;
  logic [RawW-1:0]         d1_s4;
  logic signed [TempW-1:0] temp_s4;
  logic signed [OffW-1:0]  off_s4;
  logic signed [SensW-1:0] sens_s4;
  logic signed [TempW-1:0] temp_out;
  logic signed [PresW-1:0] pres_out;

  // Calibration registers
  psc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .coef_o (coef)
  );

  // Stage valid bits and enables
  psc_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .out_ready_i (result_o.ready),
    .ctrl_o      (ctrl)
  );

  // Temperature, OFF and SENS
  psc_temp_path u_temp (
    .clk_i             (clk_i),
    .ctrl_i            (ctrl),
    .coef_i            (coef),
    .raw_pressure_i    (sample_i.raw_pressure),
    .raw_temperature_i (sample_i.raw_temperature),
    .d1_o              (d1_s4),
    .temp_o            (temp_s4),
    .off_o             (off_s4),
    .sens_o            (sens_s4)
  );

  // Pressure
  psc_pres_path u_pres (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .d1_i   (d1_s4),
    .temp_i (temp_s4),
    .off_i  (off_s4),
    .sens_i (sens_s4),
    .temp_o (temp_out),
    .pres_o (pres_out)
  );

  // Channel hookup
  assign sample_i.ready               = ctrl.en[0];
  assign result_o.valid               = ctrl.valid[NumStages-1];
  assign result_o.temperature_centi   = temp_out;
  assign result_o.pressure_centi_mbar = pres_out;

  // An accepted word occupies the first stage on the next cycle
  a_accept_fills_stage0 : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    sample_i.valid && sample_i.ready |=> ctrl.valid[0]
  ) else $error("accepted word did not enter stage 0");

  // The last stage only holds when its result waits on the sink
  a_hold_only_on_stall : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !ctrl.en[NumStages-1] |-> result_o.valid && !result_o.ready
  ) else $error("last stage held without a stall");

  // Any empty stage lets the input take a word
  a_ready_with_bubble : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !(&ctrl.valid) |-> sample_i.ready
  ) else $error("input not ready while a stage is empty");

  // A first stage that cannot load still holds its word next cycle
  a_stage0_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !ctrl.en[0] |=> ctrl.valid[0]
  ) else $error("stalled stage 0 lost its word");

endmodule

// ===== sv/psc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// psc_cfg_regs
// Calibration word registers C1..C6, written through the config channel.
// ----------------------------------------------------------------------------
module psc_cfg_regs import psc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  psc_cfg_if.sink       cfg_i,
  output psc_coef_t     coef_o
);

  psc_coef_t coef_q;
  psc_coef_t coef_d;

  // Always take a write word; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_comb begin
    coef_d = coef_q;
    if (cfg_i.valid) begin
      case (psc_cfg_idx_e'(cfg_i.index))
        CfgSensBase:   coef_d.sens_base   = cfg_i.data;
        CfgOffsetBase: coef_d.offset_base = cfg_i.data;
        CfgSensTc:     coef_d.sens_tc     = cfg_i.data;
        CfgOffsetTc:   coef_d.offset_tc   = cfg_i.data;
        CfgRefTemp:    coef_d.ref_temp    = cfg_i.data;
        CfgTempSlope:  coef_d.temp_slope  = cfg_i.data;
        default:       coef_d = coef_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

// ===== sv/psc_pipe_ctrl.sv =====
// ----------------------------------------------------------------------------
// psc_pipe_ctrl
// Valid bits of the eight datapath stages and their load enables. A stage
// loads when it is empty or when the stage after it loads, so bubbles close
// up; an output stall holds each full stage that has no bubble after it.
// ----------------------------------------------------------------------------
module psc_pipe_ctrl import psc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_ready_i,
  output psc_pipe_t ctrl_o
);

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  logic [NumStages-1:0] en;

  // Backward enable chain
  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  // Advance valid bits where a stage loads
  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl_o.valid = valid_q;
  assign ctrl_o.en    = en;

endmodule

// ===== sv/psc_temp_path.sv =====
// ----------------------------------------------------------------------------
// psc_temp_path
// Stages 0 to 4: dT, the four products on dT, first-order TEMP, OFF and
// SENS, the second-order terms and the final clamped temperature.
// ----------------------------------------------------------------------------
module psc_temp_path import psc_pkg::*; (
  input  logic                    clk_i,
  input  psc_pipe_t               ctrl_i,
  input  psc_coef_t               coef_i,
  input  logic [RawW-1:0]         raw_pressure_i,
  input  logic [RawW-1:0]         raw_temperature_i,
  output logic [RawW-1:0]         d1_o,
  output logic signed [TempW-1:0] temp_o,
  output logic signed [OffW-1:0]  off_o,
  output logic signed [SensW-1:0] sens_o
);

  localparam int D1Stages = 5;

  // D1 rides along stages 0..4
  logic [RawW-1:0] d1_q [D1Stages];

  // Stage 0
  logic signed [DtW-1:0] dt_d, dt_q;

  // Stage 1
  logic signed [MulW-1:0]    slope_prod_d, slope_prod_q;
  logic signed [MulW-1:0]    otc_prod_d, otc_prod_q;
  logic signed [MulW-1:0]    stc_prod_d, stc_prod_q;
  logic signed [SqFullW-1:0] dt_sq_full;
  logic [SqW-1:0]            dt_sq_d, dt_sq_q;

  // Stage 2
  logic signed [MulW-1:0]         slope_rnd, otc_rnd, stc_rnd;
  logic [SqW+1:0]                 dt_sq3;
  logic signed [MulW-OffShift-1:0]  off_lin;
  logic signed [MulW-SensShift-1:0] sens_lin;
  logic signed [QW-1:0]           q_d, q_q2, q_q3;
  logic [T2W-1:0]                 t2_d, t2_q2, t2_q3;
  logic signed [OffW-1:0]         off1_d, off1_q2, off1_q3;
  logic signed [SensW-1:0]        sens1_d, sens1_q2, sens1_q3;

  // Stage 3
  logic signed [QqFullW-1:0] qq_full;
  logic [QqW-1:0]            qq_d, qq_q;

  // Stage 4
  logic                       cold;
  logic [QqW+1:0]             qq3;
  logic [QqW+2:0]             qq7;
  logic [QqW-2:0]             off2;
  logic [QqW-1:0]             sens2;
  logic [T2W-1:0]             t2_sel;
  logic signed [TempFullW-1:0] temp_full;
  logic signed [TempW-1:0]    temp_d, temp_q;
  logic signed [OffW-1:0]     off_d, off_q;
  logic signed [SensW-1:0]    sens_d, sens_q;

  // Carry D1 with its word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      d1_q[0] <= raw_pressure_i;
    end
    for (int k = 1; k < D1Stages; k++) begin
      if (ctrl_i.en[k]) begin
        d1_q[k] <= d1_q[k-1];
      end
    end
  end

  // Stage 0: dT = D2 - C5*256
  assign dt_d = $signed({1'b0, raw_temperature_i})
              - $signed({1'b0, coef_i.ref_temp, {RefTempShift{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      dt_q <= dt_d;
    end
  end

  // Stage 1: products on dT
  assign slope_prod_d = MulW'(dt_q) * MulW'($signed({1'b0, coef_i.temp_slope}));
  assign otc_prod_d   = MulW'(dt_q) * MulW'($signed({1'b0, coef_i.offset_tc}));
  assign stc_prod_d   = MulW'(dt_q) * MulW'($signed({1'b0, coef_i.sens_tc}));
  assign dt_sq_full   = SqFullW'(dt_q) * SqFullW'(dt_q);
  assign dt_sq_d      = dt_sq_full[SqW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) begin
      slope_prod_q <= slope_prod_d;
      otc_prod_q   <= otc_prod_d;
      stc_prod_q   <= stc_prod_d;
      dt_sq_q      <= dt_sq_d;
    end
  end

  // Stage 2: scale toward zero, first-order OFF and SENS, T2
  assign slope_rnd = slope_prod_q
                   + $signed({{(MulW-TempShift){1'b0}}, {TempShift{slope_prod_q[MulW-1]}}});
  assign otc_rnd   = otc_prod_q
                   + $signed({{(MulW-OffShift){1'b0}}, {OffShift{otc_prod_q[MulW-1]}}});
  assign stc_rnd   = stc_prod_q
                   + $signed({{(MulW-SensShift){1'b0}}, {SensShift{stc_prod_q[MulW-1]}}});

  assign q_d      = slope_rnd[TempShift+QW-1:TempShift];
  assign off_lin  = otc_rnd[MulW-1:OffShift];
  assign sens_lin = stc_rnd[MulW-1:SensShift];

  assign dt_sq3 = {2'b00, dt_sq_q} + {1'b0, dt_sq_q, 1'b0};
  assign t2_d   = dt_sq3[T2Shift+T2W-1:T2Shift];

  assign off1_d  = OffW'($signed({1'b0, coef_i.offset_base, {OffBaseShift{1'b0}}}))
                 + OffW'(off_lin);
  assign sens1_d = SensW'($signed({1'b0, coef_i.sens_base, {SensBaseShift{1'b0}}}))
                 + SensW'(sens_lin);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      q_q2     <= q_d;
      t2_q2    <= t2_d;
      off1_q2  <= off1_d;
      sens1_q2 <= sens1_d;
    end
  end

  // Stage 3: square of TEMP - 2000
  assign qq_full = QqFullW'(q_q2) * QqFullW'(q_q2);
  assign qq_d    = qq_full[QqW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[3]) begin
      qq_q     <= qq_d;
      q_q3     <= q_q2;
      t2_q3    <= t2_q2;
      off1_q3  <= off1_q2;
      sens1_q3 <= sens1_q2;
    end
  end

  // Stage 4: apply second-order terms below 20.00 C, clamp temperature
  assign cold  = q_q3[QW-1];
  assign qq3   = {2'b00, qq_q} + {1'b0, qq_q, 1'b0};
  assign qq7   = {qq_q, 3'b000} - {3'b000, qq_q};
  assign off2  = cold ? qq3[QqW+1:Frac2Shift] : '0;
  assign sens2 = cold ? qq7[QqW+2:Frac2Shift] : '0;
  assign t2_sel = cold ? t2_q3 : '0;

  assign off_d  = off1_q3 - OffW'($signed({1'b0, off2}));
  assign sens_d = sens1_q3 - SensW'($signed({1'b0, sens2}));

  assign temp_full = TempFullW'(TempRefCenti) + TempFullW'(q_q3)
                   - TempFullW'($signed({1'b0, t2_sel}));

  always_comb begin
    if (temp_full > TempFullW'(TempMax)) begin
      temp_d = TempW'(TempMax);
    end else if (temp_full < TempFullW'(TempMin)) begin
      temp_d = TempW'(TempMin);
    end else begin
      temp_d = temp_full[TempW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[4]) begin
      temp_q <= temp_d;
      off_q  <= off_d;
      sens_q <= sens_d;
    end
  end

  assign d1_o   = d1_q[D1Stages-1];
  assign temp_o = temp_q;
  assign off_o  = off_q;
  assign sens_o = sens_q;

endmodule

// ===== sv/psc_pres_path.sv =====
// ----------------------------------------------------------------------------
// psc_pres_path
// Stages 5 to 7: D1*SENS as two partial products, the 2^21 scaling, the
// offset subtraction, the 2^15 scaling and the pressure clamp.
// ----------------------------------------------------------------------------
module psc_pres_path import psc_pkg::*; (
  input  logic                    clk_i,
  input  psc_pipe_t               ctrl_i,
  input  logic [RawW-1:0]         d1_i,
  input  logic signed [TempW-1:0] temp_i,
  input  logic signed [OffW-1:0]  off_i,
  input  logic signed [SensW-1:0] sens_i,
  output logic signed [TempW-1:0] temp_o,
  output logic signed [PresW-1:0] pres_o
);

  // Stage 5
  logic [SplitW-1:0]             sens_lo;
  logic signed [SensW-SplitW-1:0] sens_hi;
  logic [LoProdW-1:0]            lo_prod_d, lo_prod_q;
  logic signed [HiProdW-1:0]     hi_prod_d, hi_prod_q;
  logic signed [TempW-1:0]       temp_q5, temp_q6, temp_q7;
  logic signed [OffW-1:0]        off_q5, off_q6;

  // Stage 6
  logic signed [ProdW-1:0] prod, prod_rnd;
  logic signed [PdivW-1:0] pdiv_d, pdiv_q;

  // Stage 7
  logic signed [DiffW-1:0]     diff, diff_rnd;
  logic signed [PresFullW-1:0] pres_full;
  logic signed [PresW-1:0]     pres_d, pres_q;

  // Stage 5: split SENS and multiply each half by D1
  assign sens_lo   = sens_i[SplitW-1:0];
  assign sens_hi   = sens_i[SensW-1:SplitW];
  assign lo_prod_d = LoProdW'(d1_i) * LoProdW'(sens_lo);
  assign hi_prod_d = HiProdW'($signed({1'b0, d1_i})) * HiProdW'(sens_hi);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[5]) begin
      lo_prod_q <= lo_prod_d;
      hi_prod_q <= hi_prod_d;
      temp_q5   <= temp_i;
      off_q5    <= off_i;
    end
  end

  // Stage 6: merge halves, divide by 2^21 toward zero
  assign prod     = (ProdW'(hi_prod_q) <<< SplitW) + ProdW'($signed({1'b0, lo_prod_q}));
  assign prod_rnd = prod
                  + $signed({{(ProdW-ProdShift){1'b0}}, {ProdShift{prod[ProdW-1]}}});
  assign pdiv_d   = prod_rnd[ProdW-1:ProdShift];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[6]) begin
      pdiv_q  <= pdiv_d;
      temp_q6 <= temp_q5;
      off_q6  <= off_q5;
    end
  end

  // Stage 7: subtract OFF, divide by 2^15 toward zero, clamp
  assign diff      = DiffW'(pdiv_q) - DiffW'(off_q6);
  assign diff_rnd  = diff
                   + $signed({{(DiffW-PresShift){1'b0}}, {PresShift{diff[DiffW-1]}}});
  assign pres_full = diff_rnd[DiffW-1:PresShift];

  always_comb begin
    if (pres_full > PresFullW'(PresMax)) begin
      pres_d = PresW'(PresMax);
    end else if (pres_full < PresFullW'(PresMin)) begin
      pres_d = PresW'(PresMin);
    end else begin
      pres_d = pres_full[PresW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[7]) begin
      pres_q  <= pres_d;
      temp_q7 <= temp_q6;
    end
  end

  assign temp_o = temp_q7;
  assign pres_o = pres_q;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives raw D1/D2 words into the compensation pipeline under random source
// gaps and sink stalls, programs the six calibration words between phases,
// and checks every temperature and pressure result against a fixed value or a
// 64-bit integer model of the second-order compensation.
// ----------------------------------------------------------------------------
module testbench import psc_pkg::*; ();

  localparam int          NumProbes  = 21;
  localparam int          NumCalRuns = 10;
  localparam int          RunLength  = 155;
  localparam int          MaxWait    = 17;
  localparam longint      TimeoutNs  = 3_000_000;
  // Register indexes past the last calibration word: writes are dropped
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;

  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic signed [PresW-1:0] pres;
  } reading_t;

  typedef struct packed {
    logic [2:0]      cal_run;
    logic [RawW-1:0] raw_p;
    logic [RawW-1:0] raw_t;
    logic            fixed;
    reading_t        want;
  } probe_t;

  typedef struct packed {
    logic [5:0] pick;
    logic       spare;
    psc_coef_t  words;
  } cal_step_t;

  logic clk_i;
  logic rst_ni;

  psc_cfg_if cfg_bus ();
  psc_in_if  sample_bus ();
  psc_out_if result_bus ();

  pressure_sensor_compensation u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .sample_i (sample_bus),
    .result_o (result_bus)
  );

  psc_coef_t cal_words;
  reading_t  pending_readings[$];
  int        fail_count;
  bit        sample_steady;
  bit        result_steady;

  // Calibration settings of the directed part
  cal_step_t cal_steps [5] = '{
    '{6'h00, 1'b0, '0},
    '{6'h00, 1'b1, '0},
    '{6'h3f, 1'b0, '{16'd46546, 16'd42845, 16'd29751, 16'd29457, 16'd32745,
                     16'd29059}},
    '{6'h3f, 1'b0, '{default: 16'hFFFF}},
    '{6'h3f, 1'b0, '0}
  };

  // Directed words; with all calibration words zero the result is fixed
  probe_t probes [NumProbes] = '{
    '{3'd0, 24'h000000, 24'h000000, 1'b1, '{19'sd2000, 25'sd0}},
    '{3'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, '{19'sd2000, 25'sd0}},
    '{3'd0, 24'hFFFFFF, 24'h000000, 1'b1, '{19'sd2000, 25'sd0}},
    '{3'd0, 24'h000000, 24'hFFFFFF, 1'b1, '{19'sd2000, 25'sd0}},
    '{3'd1, 24'd123456, 24'd8000000, 1'b1, '{19'sd2000, 25'sd0}},
    '{3'd1, 24'hFFFFFF, 24'h800000, 1'b1, '{19'sd2000, 25'sd0}},
    '{3'd2, 24'h000000, 24'h000000, 1'b0, '0},
    '{3'd2, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
    '{3'd2, 24'd4311550, 24'd8077636, 1'b0, '0},
    '{3'd2, 24'd4311550, 24'd8382720, 1'b0, '0},
    '{3'd2, 24'd4311550, 24'd8382719, 1'b0, '0},
    '{3'd2, 24'd8000000, 24'd6000000, 1'b0, '0},
    '{3'd2, 24'hFFFFFF, 24'h000000, 1'b0, '0},
    '{3'd2, 24'h000000, 24'hFFFFFF, 1'b0, '0},
    '{3'd3, 24'h000000, 24'h000000, 1'b0, '0},
    '{3'd3, 24'hFFFFFF, 24'h000000, 1'b0, '0},
    '{3'd3, 24'h000000, 24'hFFFFFF, 1'b0, '0},
    '{3'd3, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
    '{3'd3, 24'h800000, 24'hFFFF00, 1'b0, '0},
    '{3'd4, 24'hFFFFFF, 24'hFFFFFF, 1'b1, '{19'sd2000, 25'sd0}},
    '{3'd4, 24'h000000, 24'h000000, 1'b1, '{19'sd2000, 25'sd0}}
  };

  // Compensated temperature and pressure for one raw word pair
  function automatic reading_t compensate_sample(logic [RawW-1:0] d1_raw,
                                                 logic [RawW-1:0] d2_raw);
    longint   d1, d2, c1, c2, c3, c4, c5, c6;
    longint   dt, temp, dd, t2, off2, sens2, off, sens, pres;
    reading_t r;
    d1 = d1_raw;
    d2 = d2_raw;
    c1 = cal_words.sens_base;
    c2 = cal_words.offset_base;
    c3 = cal_words.sens_tc;
    c4 = cal_words.offset_tc;
    c5 = cal_words.ref_temp;
    c6 = cal_words.temp_slope;
    dt = d2 - (c5 <<< RefTempShift);
    temp = TempRefCenti + (dt * c6) / (64'sd1 <<< TempShift);
    t2 = 0;
    off2 = 0;
    sens2 = 0;
    // Second-order terms only below the reference temperature
    if (temp < TempRefCenti) begin
      dd = temp - TempRefCenti;
      t2 = (3 * (dt * dt)) / (64'sd1 <<< T2Shift);
      off2 = (3 * (dd * dd)) / (64'sd1 <<< Frac2Shift);
      sens2 = (7 * (dd * dd)) / (64'sd1 <<< Frac2Shift);
    end
    off = (c2 <<< OffBaseShift) + (c4 * dt) / (64'sd1 <<< OffShift) - off2;
    sens = (c1 <<< SensBaseShift) + (c3 * dt) / (64'sd1 <<< SensShift) - sens2;
    temp = temp - t2;
    pres = ((d1 * sens) / (64'sd1 <<< ProdShift) - off) / (64'sd1 <<< PresShift);
    // Saturate to the output ranges
    if (temp < TempMin) temp = TempMin;
    if (temp > TempMax) temp = TempMax;
    if (pres < PresMin) pres = PresMin;
    if (pres > PresMax) pres = PresMax;
    r.temp = temp[TempW-1:0];
    r.pres = pres[PresW-1:0];
    return r;
  endfunction

  // Calibration word biased toward both extremes
  function automatic logic [CoefW-1:0] pick_coef();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      default: return CoefW'($urandom());
    endcase
  endfunction

  // Write one register and track it in the local calibration copy
  task automatic write_coef(input logic [CfgIdxW-1:0] idx,
                            input logic [CoefW-1:0] word);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= word;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      CfgSensBase:   cal_words.sens_base   = word;
      CfgOffsetBase: cal_words.offset_base = word;
      CfgSensTc:     cal_words.sens_tc     = word;
      CfgOffsetTc:   cal_words.offset_tc   = word;
      CfgRefTemp:    cal_words.ref_temp    = word;
      CfgTempSlope:  cal_words.temp_slope  = word;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic apply_cal(input psc_coef_t c, input logic [5:0] pick,
                           input logic spare);
    if (pick[0]) write_coef(CfgSensBase,   c.sens_base);
    if (pick[1]) write_coef(CfgOffsetBase, c.offset_base);
    if (pick[2]) write_coef(CfgSensTc,     c.sens_tc);
    if (pick[3]) write_coef(CfgOffsetTc,   c.offset_tc);
    if (pick[4]) write_coef(CfgRefTemp,    c.ref_temp);
    if (pick[5]) write_coef(CfgTempSlope,  c.temp_slope);
    if (spare) begin
      write_coef(CfgSpareLo, CoefW'($urandom()));
      write_coef(CfgSpareHi, CoefW'($urandom()));
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Offer one word after a random gap; predict its result on acceptance
  task automatic send_sample(input logic [RawW-1:0] raw_p,
                             input logic [RawW-1:0] raw_t,
                             input logic fixed, input reading_t want);
    int unsigned gap;
    gap = sample_steady ? 0 : $urandom_range(0, MaxWait);
    if (gap != 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sample_bus.valid           <= 1'b1;
    sample_bus.raw_pressure    <= raw_p;
    sample_bus.raw_temperature <= raw_t;
    do @(posedge clk_i); while (!sample_bus.ready);
    pending_readings.push_back(fixed ? want : compensate_sample(raw_p, raw_t));
    @(negedge clk_i);
  endtask

  // Hold the input until every expected result is out and the stages empty
  task automatic settle_pipeline();
    sample_bus.valid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk_i);
    repeat (NumStages) @(negedge clk_i);
  endtask

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Result sink: random stalls, compare each word with the oldest prediction
  initial begin : result_sink
    int unsigned stall;
    reading_t    want;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = result_steady ? 0 : $urandom_range(0, MaxWait);
      if (stall != 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!result_bus.valid);
      if (pending_readings.size() == 0) begin
        $error("unexpected result: temperature_centi %0d, pressure_centi_mbar %0d",
               result_bus.temperature_centi, result_bus.pressure_centi_mbar);
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        if (result_bus.temperature_centi !== want.temp) begin
          $error("temperature_centi: expected %0d, got %0d", want.temp,
                 result_bus.temperature_centi);
          fail_count++;
        end
        if (result_bus.pressure_centi_mbar !== want.pres) begin
          $error("pressure_centi_mbar: expected %0d, got %0d", want.pres,
                 result_bus.pressure_centi_mbar);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [2:0]       cal_run;
    psc_coef_t        cal_next;
    logic [RawW-1:0]  raw_p;
    logic [RawW-1:0]  raw_t;
    int               span;
    int               near;

    fail_count       = 0;
    cal_words        = '0;
    sample_steady    = 1'b0;
    result_steady    = 1'b0;
    rst_ni           = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = '0;
    cfg_bus.data     = '0;
    sample_bus.valid = 1'b0;
    sample_bus.raw_pressure    = '0;
    sample_bus.raw_temperature = '0;
    result_bus.ready = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words, grouped by calibration setting
    cal_run = 3'd0;
    for (int i = 0; i < NumProbes; i++) begin
      if (probes[i].cal_run != cal_run) begin
        settle_pipeline();
        cal_run = probes[i].cal_run;
        apply_cal(cal_steps[cal_run].words, cal_steps[cal_run].pick,
                  cal_steps[cal_run].spare);
      end
      send_sample(probes[i].raw_p, probes[i].raw_t, probes[i].fixed,
                  probes[i].want);
    end

    // Random calibration settings, each followed by a run of random words
    for (int run = 0; run < NumCalRuns; run++) begin
      settle_pipeline();
      cal_next.sens_base   = pick_coef();
      cal_next.offset_base = pick_coef();
      cal_next.sens_tc     = pick_coef();
      cal_next.offset_tc   = pick_coef();
      cal_next.ref_temp    = pick_coef();
      cal_next.temp_slope  = pick_coef();
      apply_cal(cal_next, (run == 0) ? 6'h3f : 6'($urandom()),
                $urandom_range(0, 3) == 0);
      sample_steady = ($urandom_range(0, 3) == 0);
      result_steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < RunLength; k++) begin
        raw_p = RawW'($urandom());
        case ($urandom_range(0, 3))
          // Around the reference temperature, where the cold branch starts
          0: begin
            span = 1 << $urandom_range(0, 20);
            near = int'(cal_words.ref_temp) * 256
                 + int'($urandom_range(0, 2 * span)) - span;
            if (near < 0) near = 0;
            if (near > 24'hFFFFFF) near = 24'hFFFFFF;
            raw_t = RawW'(near);
          end
          // Field extremes
          1: begin
            raw_p = $urandom_range(0, 1) ? '1 : '0;
            raw_t = $urandom_range(0, 1) ? '1 : '0;
          end
          default: raw_t = RawW'($urandom());
        endcase
        send_sample(raw_p, raw_t, 1'b0, '0);
      end
    end

    settle_pipeline();
    repeat (2 * NumStages) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(TimeoutNs);
    $display("testbench failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/psc_pkg.sv
sv/psc_if.sv
sv/psc_cfg_regs.sv
sv/psc_pipe_ctrl.sv
sv/psc_temp_path.sv
sv/psc_pres_path.sv
sv/pressure_sensor_compensation.sv
dv/testbench.sv
